### hdl/twc_pkg.sv
// shared types and constants of the two-way write-through cache
package twc_pkg;

  localparam int unsigned AddrW   = 32;
  localparam int unsigned DataW   = 32;
  localparam int unsigned ActW    = 2;
  localparam int unsigned CfgW    = 13;
  localparam int unsigned InTdataW  = 72;
  localparam int unsigned OutTdataW = 104;
  localparam logic [CfgW-1:0] MemWordsReset = 13'd4096;

  localparam logic [ActW-1:0] ActRead    = 2'd0;
  localparam logic [ActW-1:0] ActWrite   = 2'd1;
  localparam logic [ActW-1:0] ActPreload = 2'd2;

  typedef enum logic [2:0] {
    StIdle,
    StLook,
    StFill,
    StAccess,
    StRdWait,
    StDone
  } ctrl_state_e;

  typedef struct packed {
    logic latch;
    logic look;
    logic fill;
    logic access;
    logic capture;
    logic load_out;
  } twc_cmd_t;

  typedef struct packed {
    logic [ActW-1:0] action;
    logic            hit;
    logic            fill_err;
    logic            fill_done;
  } twc_status_t;

endpackage

### hdl/twc_ctrl.sv
// controller state machine of the two-way write-through cache
module twc_ctrl import twc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  twc_status_t status_i,
  output twc_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = StLook;
        end
      end
      StLook: begin
        cmd_o.look = 1'b1;
        if (status_i.action != ActRead && status_i.action != ActWrite) begin
          state_d = StDone;
        end else if (status_i.hit) begin
          state_d = StAccess;
        end else if (status_i.fill_err) begin
          state_d = StDone;
        end else begin
          state_d = StFill;
        end
      end
      StFill: begin
        cmd_o.fill = 1'b1;
        if (status_i.fill_done) begin
          state_d = StAccess;
        end
      end
      StAccess: begin
        cmd_o.access = 1'b1;
        state_d = (status_i.action == ActRead) ? StRdWait : StDone;
      end
      StRdWait: begin
        cmd_o.capture = 1'b1;
        state_d       = StDone;
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign out_valid_o = out_valid_q;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a pending result");
  a_accept_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == StLook)
    else $error("accepted item not looked up");
  a_fill_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StLook && state_d == StFill) |-> (!status_i.hit && !status_i.fill_err))
    else $error("fill started without a clean miss");

endmodule

### hdl/twc_datapath.sv
// tag store, line memory, backing memory and counters of the cache
module twc_datapath import twc_pkg::*; #(
  parameter int unsigned SET_COUNT      = 16,
  parameter int unsigned WORDS_PER_LINE = 4,
  parameter int unsigned MEMORY_DEPTH   = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgW-1:0]      cfg_data_i,
  input  logic [ActW-1:0]      action_i,
  input  logic [AddrW-1:0]     address_i,
  input  logic [DataW-1:0]     write_data_i,
  input  twc_cmd_t             cmd_i,
  output twc_status_t          status_o,
  output logic [DataW-1:0]     read_data_o,
  output logic                 miss_o,
  output logic                 error_o,
  output logic [DataW-1:0]     hit_count_o,
  output logic [DataW-1:0]     miss_count_o
);

  localparam int unsigned OffB  = $clog2(WORDS_PER_LINE);
  localparam int unsigned SetB  = $clog2(SET_COUNT);
  localparam int unsigned SetW  = (SetB > 0) ? SetB : 1;
  localparam int unsigned TagW  = 30 - OffB - SetB;
  localparam int unsigned MemAW = $clog2(MEMORY_DEPTH);
  localparam int unsigned LineD = 2 * SET_COUNT * WORDS_PER_LINE;
  localparam int unsigned LineAW = $clog2(LineD);
  localparam int unsigned CntW  = $clog2(WORDS_PER_LINE + 1);
  localparam logic [31:0] Wpl   = WORDS_PER_LINE;
  localparam logic [31:0] Depth = MEMORY_DEPTH;

  logic [CfgW-1:0]  mw_q;
  logic [ActW-1:0]  act_q;
  logic [29:0]      word_q;
  logic [DataW-1:0] wd_q;

  logic [SET_COUNT-1:0] v0_q, v1_q, lru_q;
  logic [TagW-1:0]      tag0_q [SET_COUNT];
  logic [TagW-1:0]      tag1_q [SET_COUNT];

  logic [DataW-1:0] bmem [MEMORY_DEPTH];
  logic [DataW-1:0] lmem [LineD];
  logic [DataW-1:0] bq, lq;

  logic             way_q;
  logic [CntW-1:0]  cnt_q;
  logic [DataW-1:0] rd_q, hits_q, misses_q;
  logic             err_q, miss_q;

  logic [31:0]      word32, off32, line32, set32, base32, limit32;
  logic [SetW-1:0]  set_idx;
  logic [TagW-1:0]  tag;
  logic             hit0, hit1, hit, victim, fill_err, pre_err, is_acc;

  always_comb begin
    word32  = {2'b00, word_q};
    off32   = word32 % Wpl;
    line32  = word32 / Wpl;
    set32   = line32 % SET_COUNT;
    base32  = word32 - off32;
    limit32 = ({19'd0, mw_q} > Depth) ? Depth : {19'd0, mw_q};
    set_idx = set32[SetW-1:0];
    tag     = TagW'(line32 / SET_COUNT);
    hit0    = v0_q[set_idx] && tag0_q[set_idx] == tag;
    hit1    = v1_q[set_idx] && tag1_q[set_idx] == tag;
    hit     = hit0 || hit1;
    victim  = !v0_q[set_idx] ? 1'b0 : (!v1_q[set_idx] ? 1'b1 : lru_q[set_idx]);
    is_acc  = (act_q == ActRead) || (act_q == ActWrite);
    fill_err = !hit && ((base32 + Wpl) > limit32);
    pre_err  = word32 >= limit32;
  end

  assign status_o.action    = act_q;
  assign status_o.hit       = hit;
  assign status_o.fill_err  = fill_err;
  assign status_o.fill_done = cnt_q == CntW'(WORDS_PER_LINE);

  // memory port selection
  logic             bwe, lwe;
  logic [MemAW-1:0] bwa, bra;
  logic [LineAW-1:0] lwa, lra;
  logic [DataW-1:0] lwd;
  logic [31:0]      slot_base, cnt32;

  always_comb begin
    cnt32     = {{(32-CntW){1'b0}}, cnt_q};
    slot_base = (set32 * 2 + {31'd0, way_q}) * Wpl;
    bwa = word_q[MemAW-1:0];
    bwe = cmd_i.look && ((act_q == ActPreload && !pre_err) ||
          (act_q == ActWrite && !fill_err && !pre_err));
    bra = MemAW'(base32 + cnt32);
    lwe = 1'b0;
    lwa = LineAW'(slot_base + off32);
    lwd = wd_q;
    lra = LineAW'(slot_base + off32);
    if (cmd_i.fill && cnt_q != '0) begin
      lwe = 1'b1;
      lwa = LineAW'(slot_base + cnt32 - 32'd1);
      lwd = bq;
    end else if (cmd_i.access && act_q == ActWrite) begin
      lwe = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (bwe) bmem[bwa] <= wd_q;
    bq <= bmem[bra];
  end

  always_ff @(posedge clk_i) begin
    if (lwe) lmem[lwa] <= lwd;
    lq <= lmem[lra];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      act_q  <= action_i;
      word_q <= address_i[31:2];
      wd_q   <= write_data_i;
    end
    if (cmd_i.look) begin
      way_q  <= hit ? hit1 && !hit0 : victim;
      rd_q   <= '0;
      err_q  <= (act_q == ActPreload) ? pre_err : (is_acc && fill_err);
      miss_q <= is_acc && !hit && !fill_err;
    end
    if (cmd_i.capture) rd_q <= lq;
    if (cmd_i.load_out) begin
      read_data_o  <= rd_q;
      miss_o       <= miss_q;
      error_o      <= err_q;
      hit_count_o  <= hits_q;
      miss_count_o <= misses_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mw_q     <= MemWordsReset;
      v0_q     <= '0;
      v1_q     <= '0;
      lru_q    <= '0;
      hits_q   <= '0;
      misses_q <= '0;
      cnt_q    <= '0;
      for (int i = 0; i < SET_COUNT; i++) begin
        tag0_q[i] <= '0;
        tag1_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) mw_q <= cfg_data_i;
      if (cmd_i.look) cnt_q <= '0;
      if (cmd_i.fill && cnt_q != CntW'(WORDS_PER_LINE)) cnt_q <= cnt_q + CntW'(1);
      if (cmd_i.look && is_acc && !fill_err) begin
        if (hit) begin
          hits_q <= hits_q + 32'd1;
          lru_q[set_idx] <= hit0;
        end else begin
          misses_q <= misses_q + 32'd1;
          lru_q[set_idx] <= !victim;
          if (victim) begin
            v1_q[set_idx]   <= 1'b1;
            tag1_q[set_idx] <= tag;
          end else begin
            v0_q[set_idx]   <= 1'b1;
            tag0_q[set_idx] <= tag;
          end
        end
      end
    end
  end

endmodule

### hdl/two_way_write_through_cache_core.sv
// top level of the two-way write-through cache
// usage:
//   slave stream carries one request per transaction: action, byte address and
//   write data; master stream returns one result per request
//   config channel writes memory_words at any time the block is idle
// actions: read word, write word (write-through, write-allocate), preload a
//   backing word, unused code answers with zero read data, miss and error
// throughput: one request at a time; the next request is taken once the
//   result sits in the output register, set by the lookup / fill sequencer
// reset: tags, valid and lru bits, hit and miss counters clear at once, no
//   clearing pass; backing memory stays undefined until preloaded or written
// stall: a result waits in the output register while m_axis_tready_i is low;
//   the following request is looked up meanwhile and waits before its load
module two_way_write_through_cache_core import twc_pkg::*; #(
  parameter int unsigned SET_COUNT      = 16,
  parameter int unsigned WORDS_PER_LINE = 4,
  parameter int unsigned MEMORY_DEPTH   = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgW-1:0]      cfg_data_i,      // memory_words
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [InTdataW-1:0]  s_axis_tdata_i,  // action, address, write_data
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [OutTdataW-1:0] m_axis_tdata_o   // read_data, miss, error, hit_count,
                                                // miss_count, zero pad
);

  twc_cmd_t    cmd;
  twc_status_t status;
  logic [DataW-1:0] read_data, hit_count, miss_count;
  logic             miss, error;

  // config always taken, block is idle by contract
  assign cfg_ready_o = 1'b1;

  twc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  twc_datapath #(
    .SET_COUNT      (SET_COUNT),
    .WORDS_PER_LINE (WORDS_PER_LINE),
    .MEMORY_DEPTH   (MEMORY_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .action_i     (s_axis_tdata_i[1:0]),
    .address_i    (s_axis_tdata_i[33:2]),
    .write_data_i (s_axis_tdata_i[65:34]),
    .cmd_i        (cmd),
    .status_o     (status),
    .read_data_o  (read_data),
    .miss_o       (miss),
    .error_o      (error),
    .hit_count_o  (hit_count),
    .miss_count_o (miss_count)
  );

  assign m_axis_tdata_o = {6'd0, miss_count, hit_count, error, miss, read_data};

endmodule
